FILE: sv/ptfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptfa_pkg
// Shared types and codes of the page table and frame allocator.
// ----------------------------------------------------------------------------
package ptfa_pkg;

    // request commands
    localparam logic CMD_MAP     = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic CFG_TABLE_BASE = 1'b0;
    localparam logic CFG_FRAME_BASE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_WINDOW   = 2'd1,
        ST_NO_TABLE = 2'd2,
        ST_NO_FRAME = 2'd3
    } t_status;

    typedef struct packed {
        logic        command;
        logic [4:0]  process_id;
        logic [31:0] virt_addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] table_addr;
        logic        table_is_new;
        logic [7:0]  page_index;
        logic [31:0] frame_addr;
    } t_rsp;

endpackage
`default_nettype wire

FILE: sv/ptfa_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptfa_alu
// Shared registered multiply-add unit: base + index * scale, modulo 2^32.
// ----------------------------------------------------------------------------
module ptfa_alu import ptfa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_base,
    input  wire logic [31:0] i_idx,
    input  wire logic [31:0] i_scale,
    output logic      [31:0] o_sum
);
    logic [63:0] w_prod;

    // one multiply and add per cycle
    assign w_prod = i_idx * i_scale;

    always_ff @(posedge i_clk) begin
        o_sum <= i_base + w_prod[31:0];
    end
endmodule
`default_nettype wire

FILE: sv/page_table_and_frame_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_and_frame_allocator_core
// Page table lookup and LIFO table / frame allocation for a two-level MMU.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass builds both free lists,
// linking each entry to the next; no request is taken meanwhile. For a map
// request the section lookup scans the table section memory one entry per
// cycle, then a table pop when the section has none, the frame pop and two
// address computations in the shared multiply-add unit follow. A release
// request returns each owned frame to the free list, then runs one table
// scan per section of the process window, freeing the tables it finds.
// TABLE_BYTES and PAGE_BYTES must be powers of two.
module page_table_and_frame_allocator_core import ptfa_pkg::*; #(
    parameter int NUM_TABLES           = 64,
    parameter int NUM_FRAMES           = 1024,
    parameter int NUM_PROCESSES        = 32,
    parameter int SECTIONS_PER_PROCESS = 32,
    parameter int TABLE_BYTES          = 1024,
    parameter int PAGE_BYTES           = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire t_req        i_req,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output t_rsp             o_rsp
);
    localparam int PPS     = TABLE_BYTES / 4;
    localparam int PAGE_SH = $clog2(PAGE_BYTES);
    localparam int SEC_SH  = $clog2(PPS) + PAGE_SH;
    localparam int SEC_W   = 32 - SEC_SH;
    localparam int TI_W    = $clog2(NUM_TABLES + 1);
    localparam int TA_W    = $clog2(NUM_TABLES);
    localparam int FI_W    = $clog2(NUM_FRAMES + 1);
    localparam int FA_W    = $clog2(NUM_FRAMES);
    localparam int PW      = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int SW      = (SECTIONS_PER_PROCESS > 1) ? $clog2(SECTIONS_PER_PROCESS) : 1;
    localparam int INIT_N  = (NUM_TABLES > NUM_FRAMES) ? NUM_TABLES : NUM_FRAMES;
    localparam int IW      = $clog2(INIT_N + 1);

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_CHECK  = 13'b0000000000100,
        S_SCAN   = 13'b0000000001000,
        S_NEWT   = 13'b0000000010000,
        S_NEWT2  = 13'b0000000100000,
        S_FRAME  = 13'b0000001000000,
        S_FRAME2 = 13'b0000010000000,
        S_ADDR1  = 13'b0000100000000,
        S_ADDR2  = 13'b0001000000000,
        S_RFR    = 13'b0010000000000,
        S_RFR2   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [IW-1:0]     r_init, n_init;
    logic [TI_W-1:0]   r_idx, n_idx;
    logic [SW-1:0]     r_sidx, n_sidx;
    logic [TI_W-1:0]   r_thead, n_thead;
    logic [FI_W-1:0]   r_fhead, n_fhead;
    logic [NUM_TABLES-1:0] r_tuse, n_tuse;
    logic [FI_W-1:0]   r_pfh [NUM_PROCESSES];
    logic              w_pfh_we;
    logic [FI_W-1:0]   w_pfh_d;

    // payload registers
    logic [31:0]       r_tbase, r_fbase;
    t_req              r_req, n_req;
    t_rsp              r_rsp, n_rsp;
    logic [31:0]       r_sec, n_sec;
    logic [TI_W-1:0]   r_t, n_t;
    logic [FI_W-1:0]   r_f, n_f;

    // memories
    logic [SEC_W-1:0]  m_tsec  [NUM_TABLES];
    logic [TI_W-1:0]   m_tlink [NUM_TABLES];
    logic [FI_W-1:0]   m_flink [NUM_FRAMES];
    logic [FI_W-1:0]   m_fown  [NUM_FRAMES];
    logic [SEC_W-1:0]  q_tsec;
    logic [TI_W-1:0]   q_tlink;
    logic [FI_W-1:0]   q_flink, q_fown;
    logic [TA_W-1:0]   w_tsec_ra, w_tsec_wa, w_tlink_ra, w_tlink_wa;
    logic [FA_W-1:0]   w_flink_ra, w_flink_wa, w_fown_ra, w_fown_wa;
    logic              w_tsec_we, w_tlink_we, w_flink_we, w_fown_we;
    logic [SEC_W-1:0]  w_tsec_d;
    logic [TI_W-1:0]   w_tlink_d;
    logic [FI_W-1:0]   w_flink_d, w_fown_d;

    // shared unit
    logic [31:0] w_alu_base, w_alu_idx, w_alu_scale, w_alu_q;

    // derived values of the current request
    logic [31:0]       w_va_sec, w_lo, w_hi;
    logic              w_pid_ok, w_match;
    logic [PW-1:0]     w_pid;
    logic [FI_W-1:0]   w_pfh_cur;
    logic [31:0]       w_pg;

    assign w_va_sec  = 32'(r_req.virt_addr >> SEC_SH);
    assign w_lo      = 32'(r_req.process_id) * 32'(SECTIONS_PER_PROCESS);
    assign w_hi      = w_lo + 32'(SECTIONS_PER_PROCESS);
    assign w_pid_ok  = 32'(r_req.process_id) < 32'(NUM_PROCESSES);
    assign w_pid     = PW'(r_req.process_id);
    assign w_pfh_cur = r_pfh[w_pid];
    assign w_match   = r_tuse[r_idx[TA_W-1:0]] && (32'(q_tsec) == r_sec);
    assign w_pg      = (r_req.virt_addr >> PAGE_SH) & 32'(PPS - 1);

    ptfa_alu u_alu (
        .i_clk   (i_clk),
        .i_base  (w_alu_base),
        .i_idx   (w_alu_idx),
        .i_scale (w_alu_scale),
        .o_sum   (w_alu_q)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_idx   = r_idx;
        n_sidx  = r_sidx;
        n_thead = r_thead;
        n_fhead = r_fhead;
        n_tuse  = r_tuse;
        n_req   = r_req;
        n_rsp   = r_rsp;
        n_sec   = r_sec;
        n_t     = r_t;
        n_f     = r_f;
        w_pfh_we   = 1'b0;
        w_pfh_d    = w_pfh_cur;
        w_tsec_ra  = r_idx[TA_W-1:0];
        w_tsec_we  = 1'b0;
        w_tsec_wa  = r_t[TA_W-1:0];
        w_tsec_d   = r_sec[SEC_W-1:0];
        w_tlink_ra = r_thead[TA_W-1:0];
        w_tlink_we = 1'b0;
        w_tlink_wa = r_t[TA_W-1:0];
        w_tlink_d  = r_thead;
        w_flink_ra = r_fhead[FA_W-1:0];
        w_flink_we = 1'b0;
        w_flink_wa = r_f[FA_W-1:0];
        w_flink_d  = r_fhead;
        w_fown_ra  = w_pfh_cur[FA_W-1:0];
        w_fown_we  = 1'b0;
        w_fown_wa  = r_f[FA_W-1:0];
        w_fown_d   = w_pfh_cur;
        w_alu_base  = r_tbase;
        w_alu_idx   = 32'(r_t);
        w_alu_scale = 32'(TABLE_BYTES);

        unique case (r_state)
            // build free lists, entry i links to i plus one
            S_INIT: begin
                w_tlink_wa = r_init[TA_W-1:0];
                w_tlink_d  = TI_W'(r_init + IW'(1));
                w_tlink_we = r_init < IW'(NUM_TABLES);
                w_flink_wa = r_init[FA_W-1:0];
                w_flink_d  = FI_W'(r_init + IW'(1));
                w_flink_we = r_init < IW'(NUM_FRAMES);
                n_init     = r_init + IW'(1);
                if (r_init == IW'(INIT_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_rsp   = '0;
                    n_state = S_CHECK;
                end
            end
            // window check, set up the section scan or the frame release
            S_CHECK: begin
                n_idx  = '0;
                n_sidx = '0;
                w_tsec_ra = '0;
                if (r_req.command == CMD_RELEASE) begin
                    n_sec   = w_lo;
                    n_state = w_pid_ok ? S_RFR : S_OUT;
                end else if (!w_pid_ok || w_va_sec < w_lo || w_va_sec >= w_hi) begin
                    n_rsp.status = ST_WINDOW;
                    n_state      = S_OUT;
                end else begin
                    n_sec   = w_va_sec;
                    n_state = S_SCAN;
                end
            end
            // one table entry compared per cycle
            S_SCAN: begin
                w_tsec_ra = TA_W'(r_idx + TI_W'(1));
                n_idx     = r_idx + TI_W'(1);
                if (r_req.command == CMD_MAP) begin
                    if (w_match) begin
                        n_t     = r_idx;
                        n_state = S_FRAME;
                    end else if (r_idx == TI_W'(NUM_TABLES - 1)) begin
                        n_state = S_NEWT;
                    end
                end else begin
                    if (w_match || r_idx == TI_W'(NUM_TABLES - 1)) begin
                        // push the found table, go to the next section
                        if (w_match) begin
                            w_tlink_wa = r_idx[TA_W-1:0];
                            w_tlink_we = 1'b1;
                            n_thead    = r_idx;
                            n_tuse[r_idx[TA_W-1:0]] = 1'b0;
                        end
                        w_tsec_ra = '0;
                        n_idx     = '0;
                        n_sec     = r_sec + 32'd1;
                        n_sidx    = r_sidx + SW'(1);
                        if (r_sidx == SW'(SECTIONS_PER_PROCESS - 1)) begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            // pop a table
            S_NEWT: begin
                if (r_thead == TI_W'(NUM_TABLES)) begin
                    n_rsp.status = ST_NO_TABLE;
                    n_state      = S_OUT;
                end else begin
                    n_t     = r_thead;
                    n_state = S_NEWT2;
                end
            end
            S_NEWT2: begin
                n_thead   = q_tlink;
                n_tuse[r_t[TA_W-1:0]] = 1'b1;
                w_tsec_we = 1'b1;
                n_rsp.table_is_new = 1'b1;
                n_state   = S_FRAME;
            end
            // pop a frame, or undo a new table
            S_FRAME: begin
                if (r_fhead == FI_W'(NUM_FRAMES)) begin
                    if (r_rsp.table_is_new) begin
                        w_tlink_we = 1'b1;
                        n_thead    = r_t;
                        n_tuse[r_t[TA_W-1:0]] = 1'b0;
                    end
                    n_rsp = '0;
                    n_rsp.status = ST_NO_FRAME;
                    n_state      = S_OUT;
                end else begin
                    n_f     = r_fhead;
                    n_state = S_FRAME2;
                end
            end
            S_FRAME2: begin
                n_fhead   = q_flink;
                w_fown_we = 1'b1;
                w_pfh_we  = 1'b1;
                w_pfh_d   = r_f;
                n_rsp.page_index = w_pg[7:0];
                n_state   = S_ADDR1;
            end
            S_ADDR1: begin
                n_rsp.table_addr = w_alu_q;
                w_alu_base  = r_fbase;
                w_alu_idx   = 32'(r_f);
                w_alu_scale = 32'(PAGE_BYTES);
                n_state     = S_ADDR2;
            end
            S_ADDR2: begin
                n_rsp.frame_addr = w_alu_q;
                n_state          = S_OUT;
            end
            // release frames, newest first
            S_RFR: begin
                if (w_pfh_cur == FI_W'(NUM_FRAMES)) begin
                    n_state = S_SCAN;
                end else begin
                    n_f     = w_pfh_cur;
                    n_state = S_RFR2;
                end
            end
            S_RFR2: begin
                w_pfh_we   = 1'b1;
                w_pfh_d    = q_fown;
                w_flink_we = 1'b1;
                n_fhead    = r_f;
                w_tsec_ra  = '0;
                n_state    = S_RFR;
            end
            S_OUT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_idx   <= '0;
            r_sidx  <= '0;
            r_thead <= '0;
            r_fhead <= '0;
            r_tuse  <= '0;
            r_tbase <= '0;
            r_fbase <= '0;
            for (int i = 0; i < NUM_PROCESSES; i++) begin
                r_pfh[i] <= FI_W'(NUM_FRAMES);
            end
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_idx   <= n_idx;
            r_sidx  <= n_sidx;
            r_thead <= n_thead;
            r_fhead <= n_fhead;
            r_tuse  <= n_tuse;
            if (w_pfh_we) begin
                r_pfh[w_pid] <= w_pfh_d;
            end
            if (i_cfg_we && i_cfg_idx == CFG_TABLE_BASE) begin
                r_tbase <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_FRAME_BASE) begin
                r_fbase <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
        r_sec <= n_sec;
        r_t   <= n_t;
        r_f   <= n_f;
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (w_tsec_we) begin
            m_tsec[w_tsec_wa] <= w_tsec_d;
        end
        q_tsec <= m_tsec[w_tsec_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_tlink_we) begin
            m_tlink[w_tlink_wa] <= w_tlink_d;
        end
        q_tlink <= m_tlink[w_tlink_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_flink_we) begin
            m_flink[w_flink_wa] <= w_flink_d;
        end
        q_flink <= m_flink[w_flink_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_fown_we) begin
            m_fown[w_fown_wa] <= w_fown_d;
        end
        q_fown <= m_fown[w_fown_ra];
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);
    assign o_rsp       = r_rsp;
endmodule
`default_nettype wire

FILE: dv/page_table_and_frame_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_table_and_frame_allocator_core_tb
// Self-checking bench for the page table and frame allocator. A directed
// table covers window edges, section reuse and release, then random phases
// run out of tables and frames. Each response is compared with a local model
// of both free lists and the per-process frame lists.
// ----------------------------------------------------------------------------
module page_table_and_frame_allocator_core_tb;
    import ptfa_pkg::*;

    localparam int N_TBL   = 64;
    localparam int N_FRM   = 1024;
    localparam int N_PROC  = 32;
    localparam int SEC_PER = 32;
    localparam longint SEC_BYTES = 64'd1 << 20;
    localparam longint WIN_BYTES = SEC_BYTES * SEC_PER;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_TABLE_BASE;
    logic [31:0] i_cfg_data = '0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    t_rsp        o_rsp;

    page_table_and_frame_allocator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // allocator state mirror
    logic [31:0] tbl_base, frm_base;
    bit          tbl_used [N_TBL];
    int          tbl_sec  [N_TBL];
    int          tbl_link [N_TBL];
    int          tbl_head;
    int          frm_link [N_FRM];
    int          frm_head;
    int          own_link [N_FRM];
    int          proc_head[N_PROC];

    t_rsp pending_rsp[$];
    int   n_err = 0, n_rsp = 0, n_map = 0, n_rel = 0;
    int   n_status[4] = '{0, 0, 0, 0};
    int   cycles = 0;
    bit   no_idle = 1'b0;

    function automatic int lookup_table(int sec);
        for (int t = 0; t < N_TBL; t++) begin
            if (tbl_used[t] && tbl_sec[t] == sec) return t;
        end
        return N_TBL;
    endfunction

    function automatic void free_table(int t);
        if (t >= N_TBL) return;
        tbl_used[t] = 1'b0;
        tbl_link[t] = tbl_head;
        tbl_head = t;
    endfunction

    // expected response of one request, updating the mirror
    function automatic t_rsp allocate_page(t_req r);
        t_rsp   rsp;
        int     pid, sec, t, f;
        bit     fresh;
        longint va;
        rsp = '0;
        rsp.status = ST_OK;
        pid = int'(r.process_id);
        va = longint'(r.virt_addr);
        if (r.command == CMD_RELEASE) begin
            n_rel++;
            if (pid >= N_PROC) return rsp;
            while (proc_head[pid] < N_FRM) begin
                f = proc_head[pid];
                proc_head[pid] = own_link[f];
                frm_link[f] = frm_head;
                frm_head = f;
            end
            for (int i = 0; i < SEC_PER; i++) free_table(lookup_table(pid * SEC_PER + i));
            return rsp;
        end
        n_map++;
        if (pid >= N_PROC || va < pid * WIN_BYTES || va >= (pid + 1) * WIN_BYTES) begin
            rsp.status = ST_WINDOW;
            return rsp;
        end
        sec = int'(va / SEC_BYTES);
        fresh = 1'b0;
        t = lookup_table(sec);
        if (t >= N_TBL) begin
            t = tbl_head;
            if (t >= N_TBL) begin
                rsp.status = ST_NO_TABLE;
                return rsp;
            end
            tbl_head = tbl_link[t];
            tbl_used[t] = 1'b1;
            tbl_sec[t] = sec;
            fresh = 1'b1;
        end
        f = frm_head;
        if (f >= N_FRM) begin
            if (fresh) free_table(t);
            rsp.status = ST_NO_FRAME;
            return rsp;
        end
        frm_head = frm_link[f];
        own_link[f] = proc_head[pid];
        proc_head[pid] = f;
        rsp.table_addr   = tbl_base + 32'(t) * 32'd1024;
        rsp.table_is_new = fresh;
        rsp.page_index   = r.virt_addr[19:12];
        rsp.frame_addr   = frm_base + 32'(f) * 32'd4096;
        return rsp;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request and record its expected response on acceptance
    task automatic send_request(t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req = r;
        i_req_valid = 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        pending_rsp.push_back(allocate_page(r));
        @(negedge i_clk);
    endtask

    // register write once every response is back
    task automatic write_reg(logic idx, logic [31:0] data);
        i_req_valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_TABLE_BASE) tbl_base = data;
        else frm_base = data;
    endtask

    function automatic t_req map_req(int pid, int sec_span);
        t_req r;
        r.command = CMD_MAP;
        r.process_id = 5'(pid);
        if ($urandom_range(0, 99) < 3) r.virt_addr = $urandom;
        else r.virt_addr = 32'(pid) * 32'h0200_0000
                         + (32'($urandom_range(0, sec_span - 1)) << 20)
                         + ($urandom & 32'h000F_FFFF);
        return r;
    endfunction

    function automatic t_req release_req(int pid);
        t_req r;
        r.command = CMD_RELEASE;
        r.process_id = 5'(pid);
        r.virt_addr = $urandom;
        return r;
    endfunction

    // response side stalls, mostly short and a few long
    initial begin
        int rgap;
        forever begin
            @(negedge i_clk);
            rgap = pick_gap();
            if (rgap > 0) begin
                i_rsp_ready = 1'b0;
                repeat (rgap) @(negedge i_clk);
            end
            i_rsp_ready = 1'b1;
        end
    end

    // response check
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        cycles <= cycles + 1;
        if (o_rsp_valid && i_rsp_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected response %p", o_rsp);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                n_status[exp_rsp.status]++;
                if (o_rsp.status !== exp_rsp.status || o_rsp.table_addr !== exp_rsp.table_addr
                    || o_rsp.table_is_new !== exp_rsp.table_is_new
                    || o_rsp.page_index !== exp_rsp.page_index
                    || o_rsp.frame_addr !== exp_rsp.frame_addr) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: expected %p got %p", exp_rsp, o_rsp);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    typedef struct {
        t_req r;
        bit   typed;
        t_rsp rsp;
    } t_row;

    localparam t_rsp RSP_ZERO = '{ST_OK, 32'h0, 1'b0, 8'h0, 32'h0};
    localparam t_rsp RSP_WIN  = '{ST_WINDOW, 32'h0, 1'b0, 8'h0, 32'h0};

    t_row dir_rows[] = '{
        '{'{CMD_MAP, 5'd0, 32'h0000_0000}, 1, '{ST_OK, 32'h0, 1'b1, 8'h00, 32'h0}},
        '{'{CMD_MAP, 5'd0, 32'h000F_FFFF}, 1, '{ST_OK, 32'h0, 1'b0, 8'hFF, 32'h1000}},
        '{'{CMD_MAP, 5'd0, 32'h0200_0000}, 1, RSP_WIN},
        '{'{CMD_MAP, 5'd31, 32'hFFFF_FFFF}, 1, RSP_WIN},
        '{'{CMD_MAP, 5'd31, 32'h3FFF_FFFF}, 0, RSP_ZERO},
        '{'{CMD_MAP, 5'd31, 32'h3E00_0000}, 0, RSP_ZERO},
        '{'{CMD_MAP, 5'd1, 32'h01FF_FFFF}, 1, RSP_WIN},
        '{'{CMD_MAP, 5'd1, 32'h0200_0000}, 0, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd0, 32'hFFFF_FFFF}, 1, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd0, 32'h0000_0000}, 1, RSP_ZERO},
        '{'{CMD_MAP, 5'd0, 32'h0010_0000}, 0, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd5, 32'h1234_5678}, 1, RSP_ZERO},
        '{'{CMD_MAP, 5'd16, 32'h2005_5555}, 0, RSP_ZERO},
        '{'{CMD_MAP, 5'd16, 32'h21FA_AAAA}, 0, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd31, 32'h0}, 1, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd1, 32'h0}, 1, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd0, 32'h0}, 1, RSP_ZERO},
        '{'{CMD_RELEASE, 5'd16, 32'h0}, 1, RSP_ZERO}
    };

    // stimulus
    initial begin
        int   pid;
        tbl_base = '0;
        frm_base = '0;
        for (int i = 0; i < N_TBL; i++) begin
            tbl_used[i] = 1'b0;
            tbl_sec[i] = 0;
            tbl_link[i] = i + 1;
        end
        for (int i = 0; i < N_FRM; i++) begin
            frm_link[i] = i + 1;
            own_link[i] = 0;
        end
        for (int i = 0; i < N_PROC; i++) proc_head[i] = N_FRM;
        tbl_head = 0;
        frm_head = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_reg(CFG_TABLE_BASE, 32'h0);
        write_reg(CFG_FRAME_BASE, 32'h0);

        // directed table
        no_idle = 1'b1;
        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].r);
            if (dir_rows[k].typed) begin
                void'(pending_rsp.pop_back());
                pending_rsp.push_back(dir_rows[k].rsp);
            end
            if (k == 8) no_idle = 1'b0;
        end

        // mixed traffic over a few processes, tables run out
        write_reg(CFG_TABLE_BASE, $urandom);
        write_reg(CFG_FRAME_BASE, $urandom);
        for (int n = 0; n < 600; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 4) send_request(release_req(pid));
            else send_request(map_req(pid, SEC_PER));
        end
        no_idle = 1'b0;
        for (int p = 0; p < N_PROC; p++) send_request(release_req(p));

        // fill every frame with two processes, bases at the wrap extreme
        write_reg(CFG_TABLE_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_FRAME_BASE, 32'hFFFF_FFFF);
        for (int n = 0; n < 1100; n++) begin
            if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_request(map_req($urandom_range(0, 1), SEC_PER));
        end

        // out of frames, then recovery through releases
        no_idle = 1'b0;
        write_reg(CFG_TABLE_BASE, 32'hFFFF_FC00);
        write_reg(CFG_FRAME_BASE, $urandom);
        for (int n = 0; n < 150; n++) begin
            pid = $urandom_range(0, 7);
            if ($urandom_range(0, 99) < 10) send_request(release_req(pid));
            else send_request(map_req(pid, SEC_PER));
        end
        i_req_valid = 1'b0;

        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("%0d map and %0d release requests, %0d responses checked", n_map, n_rel,
                 n_rsp);
        $display("status ok %0d, window %0d, no table %0d, no frame %0d, %0d mismatches",
                 n_status[0], n_status[1], n_status[2], n_status[3], n_err);
        if (n_err == 0 && pending_rsp.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
